@@ hdl/rto_pkg.sv @@
// rope tension observer: shared constants, types and fixed-point helpers
// used by rto_serial_unit and rope_tension_observer_top; no dependencies
package rto_pkg;

    localparam int FRAC       = 16;
    localparam int MUL_W      = 32;
    localparam int DIV_W      = 50;
    localparam int SQRT_STEPS = 25;
    localparam int SQRT_TOP   = 2 * (SQRT_STEPS - 1);
    localparam int CNT_W      = 6;

    localparam logic [63:0] HALF_Q      = 64'd1 << (FRAC - 1);
    localparam logic [31:0] ONE_Q       = 32'd1 << FRAC;
    localparam logic [49:0] MIN_LEN_SQ  =
        50'(((64'd1 << (2 * FRAC)) + 64'd99999999) / 64'd100000000);
    localparam logic [30:0] PHI_MIN     = 31'((64'd1 << FRAC) / 64'd1000000);
    localparam logic [31:0] DT_SCALE    = 32'd1000000;
    localparam logic [30:0] TENSION_MAX = 31'h7fffffff;
    localparam logic [1:0]  AXIS_LAST   = 2'd2;

    localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
    localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

    localparam logic [2:0] REG_GAIN_ONE = 3'd0;
    localparam logic [2:0] REG_GAIN_TWO = 3'd1;
    localparam logic [2:0] REG_PHI      = 3'd2;
    localparam logic [2:0] REG_CAP      = 3'd3;
    localparam logic [2:0] REG_COMP_ON  = 3'd4;
    localparam logic [2:0] REG_MASS     = 3'd5;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } rto_op_t;

    typedef struct packed {
        rto_op_t     op;
        logic [63:0] a;
        logic [31:0] b;
    } rto_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHECK,
        ST_SQRT,
        ST_AXIS,
        ST_VD,
        ST_AD,
        ST_PREP,
        ST_PT,
        ST_PC,
        ST_OBS,
        ST_L1,
        ST_S,
        ST_NV1,
        ST_NV2,
        ST_L2,
        ST_ND1,
        ST_ND2,
        ST_T,
        ST_F,
        ST_C,
        ST_DONE
    } rto_state_t;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        mag = v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [67:0] with_sign(input logic neg, input logic [63:0] m);
        logic signed [67:0] p;
        p = $signed({4'b0, m});
        with_sign = neg ? -p : p;
    endfunction

    // half away from zero on a magnitude, scaled down by the fraction bits
    function automatic logic [63:0] rnd_q(input logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, m} + {1'b0, HALF_Q};
        rnd_q = 64'(s >> FRAC);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > S32_MAX)
            sat32 = 32'sh7fffffff;
        else if (v < S32_MIN)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic [30:0] cap_tension(input logic neg, input logic [63:0] m,
                                                input logic [30:0] cap);
        logic [30:0] t;
        if (neg)
            t = '0;
        else if (m > 64'(TENSION_MAX))
            t = TENSION_MAX;
        else
            t = m[30:0];
        if (cap != '0 && t > cap)
            t = cap;
        cap_tension = t;
    endfunction

endpackage

@@ hdl/rto_serial_unit.sv @@
// shared serial arithmetic unit: shift-add multiply, restoring divide with
// round half up on magnitudes, and integer square root; one bit per cycle
// depends on rto_pkg
module rto_serial_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rto_pkg::rto_req_t req,
    output logic              done,
    output logic [63:0]       result
);
    import rto_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rto_op_t          op_reg, op_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      sh_reg, sh_next;
    logic [31:0]      den_reg, den_next;
    logic [31:0]      rem_reg, rem_next;
    logic [63:0]      bit_reg, bit_next;
    logic [32:0]      trial;
    logic [63:0]      rb;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        trial     = {rem_reg, sh_reg[DIV_W-1]};
        rb        = acc_reg + bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            rem_next  = '0;
            den_next  = req.b;
            bit_next  = 64'd1 << SQRT_TOP;
            unique case (req.op)
                OP_MUL:
                begin
                    sh_next  = req.a;
                    cnt_next = CNT_W'(MUL_W - 1);
                end
                OP_DIV:
                begin
                    // add half the divisor up front for rounding
                    sh_next  = req.a + 64'(req.b >> 1);
                    cnt_next = CNT_W'(DIV_W - 1);
                end
                OP_SQRT:
                begin
                    sh_next  = req.a;
                    cnt_next = CNT_W'(SQRT_STEPS - 1);
                end
                default:
                begin
                    sh_next  = req.a;
                    cnt_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (den_reg[0])
                        acc_next = acc_reg + sh_reg;
                    sh_next  = sh_reg << 1;
                    den_next = den_reg >> 1;
                end
                OP_DIV:
                begin
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_next = 32'(trial - {1'b0, den_reg});
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[31:0];
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                    sh_next = sh_reg << 1;
                end
                OP_SQRT:
                begin
                    if (sh_reg >= rb)
                    begin
                        sh_next  = sh_reg - rb;
                        acc_next = (acc_reg >> 1) + bit_reg;
                    end
                    else
                        acc_next = acc_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ hdl/rope_tension_observer_top.sv @@
// rope tension observer top level: sequencer, per-UAV observer state,
// configuration registers and output register; depends on rto_pkg, rto_serial_unit
//
//  channel | direction | handshake             | beat content
//  in      | input     | in_valid / in_ready   | uav_index, rel_*, vel_*, acc_*, dt_us
//  out     | output    | out_valid / out_ready | valid_res, tension, force_*, comp_*, estimates
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one item at a time; every multiply, divide and square root runs on the one
// shared serial unit at one bit per cycle (multiply 32, divide 50, root 25 steps)
// each operation also spends time on issue and completion beyond its steps
// a rejected item ends after the squared length check and skips the remaining steps
// a finished beat waits in the output register while the next item is taken
// reset clears the observer state of every UAV and loads the register defaults
module rope_tension_observer_top #(
    parameter int NUM_AGENTS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         uav_index,
    input  logic signed [23:0] rel_x,
    input  logic signed [23:0] rel_y,
    input  logic signed [23:0] rel_z,
    input  logic signed [22:0] vel_x,
    input  logic signed [22:0] vel_y,
    input  logic signed [22:0] vel_z,
    input  logic signed [23:0] acc_x,
    input  logic signed [23:0] acc_y,
    input  logic signed [23:0] acc_z,
    input  logic [17:0]        dt_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic [30:0]        tension,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z,
    output logic signed [31:0] comp_x,
    output logic signed [31:0] comp_y,
    output logic signed [31:0] comp_z,
    output logic signed [31:0] speed_estimate,
    output logic signed [31:0] disturbance_estimate,
    output logic signed [31:0] speed_error,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);
    import rto_pkg::*;

    localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;

    rto_state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       issue_reg, issue_next;
    logic       neg_reg;
    logic       res_ok_reg;

    logic [30:0] gain1_reg, gain2_reg, phi_reg, cap_reg;
    logic        comp_on_reg;
    logic [22:0] mass_reg;

    logic signed [31:0] vhat_store [NUM_AGENTS];
    logic signed [31:0] dhat_store [NUM_AGENTS];

    logic [1:0]         idx_reg;
    logic signed [23:0] rel_reg [3];
    logic signed [22:0] vel_reg [3];
    logic signed [23:0] accel_reg [3];
    logic [17:0]        dt_reg;

    logic [49:0]        sumsq_reg;
    logic [24:0]        len_reg;
    logic signed [17:0] axis_reg [3];
    logic signed [43:0] vdot_reg;
    logic signed [44:0] adot_reg;
    logic signed [31:0] vhat_reg, dhat_reg, err_reg, obs_reg, prev_comp_reg;
    logic signed [17:0] s_reg;
    logic signed [31:0] rate_reg, nv_reg, nd_reg;
    logic [30:0]        t_reg;
    logic signed [31:0] force_reg [3];
    logic signed [31:0] comp_reg [3];

    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [30:0]        out_t_reg;
    logic signed [31:0] out_f_reg [3];
    logic signed [31:0] out_c_reg [3];
    logic signed [31:0] out_nv_reg, out_nd_reg, out_err_reg;

    rto_req_t      req;
    logic          op_neg;
    logic          unit_start, unit_done;
    logic [63:0]   unit_res;
    logic          is_op, step_done, bad, out_load;
    logic [AW-1:0] sidx;
    logic [22:0]   mass_eff;

    logic signed [67:0] sv, rq, s_sv, s_sign_sv;
    logic signed [31:0] vmeas, amean, nd_new;
    logic [16:0]        s_clip;

    rto_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .req    (req),
        .done   (unit_done),
        .result (unit_res)
    );

    assign sidx      = AW'(idx_reg);
    assign mass_eff  = (mass_reg == '0) ? 23'd1 : mass_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign is_op     = !(state_reg == ST_IDLE || state_reg == ST_CHECK ||
                         state_reg == ST_PREP || state_reg == ST_OBS ||
                         state_reg == ST_DONE);
    assign step_done = is_op && issue_reg && unit_done;
    assign bad       = (dt_reg == '0) || (32'(idx_reg) >= NUM_AGENTS) ||
                       (sumsq_reg < MIN_LEN_SQ);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign sv        = with_sign(neg_reg, unit_res);
    assign rq        = with_sign(neg_reg, rnd_q(unit_res));
    assign vmeas     = sat32(with_sign(vdot_reg[43], rnd_q(mag(64'(vdot_reg)))));
    assign amean     = sat32(with_sign(adot_reg[44], rnd_q(mag(64'(adot_reg)))));
    assign s_clip    = (unit_res > 64'(ONE_Q)) ? ONE_Q[16:0] : unit_res[16:0];
    assign s_sv      = with_sign(neg_reg, {47'b0, s_clip});
    assign s_sign_sv = with_sign(err_reg[31], 64'(ONE_Q));
    assign nd_new    = sat32(68'(dhat_reg) + sv);

    // operand selection for the shared unit
    always_comb
    begin
        req    = '0;
        req.op = OP_MUL;
        op_neg = 1'b0;
        unique case (state_reg)
            ST_SQ:
            begin
                req.a = mag(64'(rel_reg[k_reg]));
                req.b = 32'(mag(64'(rel_reg[k_reg])));
            end
            ST_SQRT:
            begin
                req.op = OP_SQRT;
                req.a  = {14'b0, sumsq_reg};
            end
            ST_AXIS:
            begin
                req.op = OP_DIV;
                req.a  = mag(64'(rel_reg[k_reg])) << FRAC;
                req.b  = {7'b0, len_reg};
                op_neg = rel_reg[k_reg][23];
            end
            ST_VD:
            begin
                req.a  = mag(64'(vel_reg[k_reg]));
                req.b  = 32'(mag(64'(axis_reg[k_reg])));
                op_neg = vel_reg[k_reg][22] ^ axis_reg[k_reg][17];
            end
            ST_AD:
            begin
                req.a  = mag(64'(accel_reg[k_reg]));
                req.b  = 32'(mag(64'(axis_reg[k_reg])));
                op_neg = accel_reg[k_reg][23] ^ axis_reg[k_reg][17];
            end
            ST_PT:
            begin
                req.a  = mag(64'(dhat_reg));
                req.b  = {9'b0, mass_eff};
                op_neg = dhat_reg[31];
            end
            ST_PC:
            begin
                req.op = OP_DIV;
                req.a  = {33'b0, t_reg} << FRAC;
                req.b  = {9'b0, mass_eff};
            end
            ST_L1:
            begin
                req.a  = {33'b0, gain1_reg};
                req.b  = 32'(mag(64'(err_reg)));
                op_neg = err_reg[31];
            end
            ST_S:
            begin
                req.op = OP_DIV;
                req.a  = mag(64'(err_reg)) << FRAC;
                req.b  = {1'b0, phi_reg};
                op_neg = err_reg[31];
            end
            ST_NV1, ST_ND1:
            begin
                req.a  = mag(64'(rate_reg));
                req.b  = {14'b0, dt_reg};
                op_neg = rate_reg[31];
            end
            ST_NV2, ST_ND2:
            begin
                req.op = OP_DIV;
                req.a  = unit_res;
                req.b  = DT_SCALE;
                op_neg = neg_reg;
            end
            ST_L2:
            begin
                req.a  = {33'b0, gain2_reg};
                req.b  = 32'(mag(64'(s_reg)));
                op_neg = s_reg[17];
            end
            ST_T:
            begin
                req.a  = mag(64'(nd_reg));
                req.b  = {9'b0, mass_eff};
                op_neg = nd_reg[31];
            end
            ST_F:
            begin
                req.a  = {33'b0, t_reg};
                req.b  = 32'(mag(64'(axis_reg[k_reg])));
                op_neg = axis_reg[k_reg][17];
            end
            ST_C:
            begin
                req.op = OP_DIV;
                req.a  = mag(64'(force_reg[k_reg])) << FRAC;
                req.b  = {9'b0, mass_eff};
                op_neg = !force_reg[k_reg][31];
            end
            default:
            begin
                req.op = OP_MUL;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        issue_next = issue_reg;
        unit_start = 1'b0;
        if (is_op && !issue_reg)
        begin
            unit_start = 1'b1;
            issue_next = 1'b1;
        end
        if (step_done)
            issue_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_SQ;
                    k_next     = '0;
                end
            ST_SQ:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = ST_CHECK;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_CHECK:
                state_next = bad ? ST_DONE : ST_SQRT;
            ST_SQRT:
                if (step_done)
                    state_next = ST_AXIS;
            ST_AXIS:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = ST_VD;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_VD:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = ST_AD;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_AD:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = ST_PREP;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_PREP:
                state_next = comp_on_reg ? ST_PT : ST_OBS;
            ST_PT:
                if (step_done)
                    state_next = ST_PC;
            ST_PC:
                if (step_done)
                    state_next = ST_OBS;
            ST_OBS:
                state_next = ST_L1;
            ST_L1:
                if (step_done)
                    state_next = (phi_reg > PHI_MIN) ? ST_S : ST_NV1;
            ST_S:
                if (step_done)
                    state_next = ST_NV1;
            ST_NV1:
                if (step_done)
                    state_next = ST_NV2;
            ST_NV2:
                if (step_done)
                    state_next = ST_L2;
            ST_L2:
                if (step_done)
                    state_next = ST_ND1;
            ST_ND1:
                if (step_done)
                    state_next = ST_ND2;
            ST_ND2:
                if (step_done)
                    state_next = ST_T;
            ST_T:
                if (step_done)
                begin
                    state_next = ST_F;
                    k_next     = '0;
                end
            ST_F:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = (comp_on_reg && t_reg != '0) ? ST_C : ST_DONE;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_C:
                if (step_done)
                begin
                    if (k_reg == AXIS_LAST)
                    begin
                        state_next = ST_DONE;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            issue_reg <= issue_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain1_reg   <= '0;
            gain2_reg   <= '0;
            phi_reg     <= '0;
            cap_reg     <= '0;
            comp_on_reg <= 1'b0;
            mass_reg    <= 23'(ONE_Q);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_ONE: gain1_reg   <= cfg_data;
                REG_GAIN_TWO: gain2_reg   <= cfg_data;
                REG_PHI:      phi_reg     <= cfg_data;
                REG_CAP:      cap_reg     <= cfg_data;
                REG_COMP_ON:  comp_on_reg <= cfg_data[0];
                REG_MASS:     mass_reg    <= cfg_data[22:0];
                default:      ;
            endcase
        end
    end

    // per-UAV observer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AGENTS; i++)
            begin
                vhat_store[i] <= '0;
                dhat_store[i] <= '0;
            end
        end
        else if (state_reg == ST_ND2 && step_done)
        begin
            vhat_store[sidx] <= nv_reg;
            dhat_store[sidx] <= nd_new;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (unit_start)
            neg_reg <= op_neg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    idx_reg      <= uav_index;
                    rel_reg[0]   <= rel_x;
                    rel_reg[1]   <= rel_y;
                    rel_reg[2]   <= rel_z;
                    vel_reg[0]   <= vel_x;
                    vel_reg[1]   <= vel_y;
                    vel_reg[2]   <= vel_z;
                    accel_reg[0] <= acc_x;
                    accel_reg[1] <= acc_y;
                    accel_reg[2] <= acc_z;
                    dt_reg       <= dt_us;
                    sumsq_reg    <= '0;
                    vdot_reg     <= '0;
                    adot_reg     <= '0;
                end
            ST_SQ:
                if (step_done)
                    sumsq_reg <= sumsq_reg + unit_res[49:0];
            ST_CHECK:
            begin
                res_ok_reg <= !bad;
                for (int i = 0; i < 3; i++)
                    comp_reg[i] <= '0;
                if (!bad)
                begin
                    vhat_reg <= vhat_store[sidx];
                    dhat_reg <= dhat_store[sidx];
                end
            end
            ST_SQRT:
                if (step_done)
                    len_reg <= unit_res[24:0];
            ST_AXIS:
                if (step_done)
                    axis_reg[k_reg] <= sv[17:0];
            ST_VD:
                if (step_done)
                    vdot_reg <= vdot_reg + sv[43:0];
            ST_AD:
                if (step_done)
                    adot_reg <= adot_reg + sv[44:0];
            ST_PREP:
            begin
                err_reg       <= sat32(68'(vmeas) - 68'(vhat_reg));
                obs_reg       <= amean;
                prev_comp_reg <= '0;
            end
            ST_PT:
                if (step_done)
                    t_reg <= cap_tension(neg_reg, rnd_q(unit_res), cap_reg);
            ST_PC:
                if (step_done)
                    prev_comp_reg <= sat32(sv);
            ST_OBS:
            begin
                obs_reg <= sat32(68'(obs_reg) - 68'(prev_comp_reg));
                // sign of the error when the boundary layer is off
                s_reg   <= s_sign_sv[17:0];
            end
            ST_L1:
                if (step_done)
                    rate_reg <= sat32(68'(obs_reg) + 68'(dhat_reg) + 68'(sat32(rq)));
            ST_S:
                if (step_done)
                    s_reg <= s_sv[17:0];
            ST_NV2:
                if (step_done)
                    nv_reg <= sat32(68'(vhat_reg) + sv);
            ST_L2:
                if (step_done)
                    rate_reg <= sat32(rq);
            ST_ND2:
                if (step_done)
                    nd_reg <= nd_new;
            ST_T:
                if (step_done)
                    t_reg <= cap_tension(neg_reg, rnd_q(unit_res), cap_reg);
            ST_F:
                if (step_done)
                    force_reg[k_reg] <= sat32(rq);
            ST_C:
                if (step_done)
                    comp_reg[k_reg] <= sat32(sv);
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ok_reg  <= res_ok_reg;
            out_t_reg   <= res_ok_reg ? t_reg : '0;
            out_nv_reg  <= res_ok_reg ? nv_reg : '0;
            out_nd_reg  <= res_ok_reg ? nd_reg : '0;
            out_err_reg <= res_ok_reg ? err_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                out_f_reg[i] <= res_ok_reg ? force_reg[i] : '0;
                out_c_reg[i] <= res_ok_reg ? comp_reg[i] : '0;
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign valid_res            = out_ok_reg;
    assign tension              = out_t_reg;
    assign force_x              = out_f_reg[0];
    assign force_y              = out_f_reg[1];
    assign force_z              = out_f_reg[2];
    assign comp_x               = out_c_reg[0];
    assign comp_y               = out_c_reg[1];
    assign comp_z               = out_c_reg[2];
    assign speed_estimate       = out_nv_reg;
    assign disturbance_estimate = out_nd_reg;
    assign speed_error          = out_err_reg;

    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> issue_reg)
        else $error("arithmetic result without an issued operation");

    a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_ND2 |=> $stable(vhat_store[0]))
        else $error("observer state changed outside the update step");

    a_cap_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res && cap_reg != '0) |-> (tension <= cap_reg))
        else $error("tension above the cap");

    a_comp_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !comp_on_reg) |-> (comp_x == '0 && comp_y == '0 && comp_z == '0))
        else $error("compensation output while compensation is off");

endmodule
